// ===== sv/rti_pkg.sv =====
package rti_pkg;

  localparam int COORD_WIDTH = 21;
  localparam int FRAC_BITS = 10;

  // Packed vector of three coordinates.
  localparam int VW = 3 * COORD_WIDTH;
  // Edge and offset vectors carry one more bit than a coordinate.
  localparam int EW = COORD_WIDTH + 1;
  // Cross products, one bit wider than the wider of the two product terms.
  localparam int QW = 2 * COORD_WIDTH + 3;
  // Dot products.
  localparam int DW = 3 * COORD_WIDTH + 6;
  // Split of a cross product component for the dot-product multipliers.
  localparam int LB = COORD_WIDTH + 1;
  localparam int HW = QW - LB;
  localparam int PPW = 2 * COORD_WIDTH + 3;
  localparam int PSW = PPW + 2;
  // Chunks of a dot product for multiplication by a coordinate-sized value.
  localparam int CH = COORD_WIDTH + 2;
  localparam int CPW = CH + COORD_WIDTH;
  localparam int NW = DW + COORD_WIDTH;
  localparam int LW = DW + COORD_WIDTH + FRAC_BITS;
  // Quotient bits of one point offset, remainder width and offset sum width.
  localparam int QBITS = 2 * COORD_WIDTH - 1 - FRAC_BITS;
  localparam int RW = DW + 1;
  localparam int SUMW = QBITS + 3;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [31:0] EPS_RESET = 32'd1074;

  typedef enum logic [1:0] {
    FACE_BOTH = 2'd0,
    FACE_CW   = 2'd1,
    FACE_CCW  = 2'd2
  } face_t;

  // One classified test handed from the front end to the point unit.
  typedef struct packed {
    logic            hit;
    logic [DW-1:0]   nt;
    logic [DW-1:0]   den;
    logic [VW-1:0]   org;
    logic [VW-1:0]   dir;
  } work_t;

  function automatic logic signed [COORD_WIDTH-1:0] coord_of(input logic [VW-1:0] v,
                                                             input int i);
    coord_of = v[i*COORD_WIDTH +: COORD_WIDTH];
  endfunction

endpackage

// ===== sv/rti_front.sv =====
module rti_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rti_pkg::VW-1:0]           vertex_a,
  input  logic [rti_pkg::VW-1:0]           vertex_b,
  input  logic [rti_pkg::VW-1:0]           vertex_c,
  input  logic [rti_pkg::VW-1:0]           ray_start,
  input  logic [rti_pkg::VW-1:0]           ray_direction,
  input  logic [rti_pkg::COORD_WIDTH-1:0]  ray_length,
  input  logic [1:0]                       face_mode,
  input  logic [31:0]                      eps,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rti_pkg::work_t                   out_work
);
  import rti_pkg::*;

  typedef struct packed {
    logic [VW-1:0]          dir;
    logic [VW-1:0]          org;
    logic [COORD_WIDTH-1:0] len;
    logic                   ok;
    logic                   both;
  } ctx_t;

  logic       adv;
  logic [8:0] v;
  ctx_t       ctx [8];

  face_t fm;
  logic  m_ok, m_both, m_cw;
  logic signed [COORD_WIDTH-1:0] a_c [3], b_c [3], c_c [3], o_c [3], k0 [3], k2 [3];
  logic signed [EW-1:0] e1_n [3], e2_n [3], sv_n [3];

  logic signed [EW-1:0] e1_r [3][3], e2_r [3][3], sv_r [3][3];
  logic signed [2*COORD_WIDTH:0]   pa [3], pb [3];
  logic signed [2*COORD_WIDTH+1:0] qa [3], qb [3];
  logic signed [QW-1:0] pv [3], qv [3];
  logic signed [EW-1:0] sm [4][3];
  logic signed [QW-1:0] wd [4][3];
  logic signed [PPW-1:0] lo_pp [4][3], hi_pp [4][3];
  logic signed [PSW-1:0] lo_s [4], hi_s [4];
  logic signed [DW-1:0] dot [4];
  logic signed [DW-1:0] mag7, nu7, nv7, nt7;
  logic rej7;
  logic eps_ok, u_ok, v_ok, t_pos;
  logic signed [DW:0] uv_sum;
  logic [CPW-1:0] lp [3];
  logic [DW-1:0]  nt8, den8;
  logic           good8;
  logic [NW-1:0]  dl;
  logic [LW-1:0]  lhs, rhs;

  assign adv       = !v[8] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[8];

  always_comb begin
    fm = face_t'(face_mode);
    m_ok = 1'b1;
    m_both = 1'b0;
    m_cw = 1'b0;
    case (fm)
      FACE_BOTH: m_both = 1'b1;
      FACE_CW:   m_cw = 1'b1;
      FACE_CCW:  m_ok = 1'b1;
      default:   m_ok = 1'b0;
    endcase
    for (int i = 0; i < 3; i++) begin
      a_c[i] = coord_of(vertex_a, i);
      b_c[i] = coord_of(vertex_b, i);
      c_c[i] = coord_of(vertex_c, i);
      o_c[i] = coord_of(ray_start, i);
      // Clockwise front faces use the reversed vertex order.
      k0[i] = m_cw ? c_c[i] : a_c[i];
      k2[i] = m_cw ? a_c[i] : c_c[i];
      e1_n[i] = EW'(b_c[i]) - EW'(k0[i]);
      e2_n[i] = EW'(k2[i]) - EW'(k0[i]);
      sv_n[i] = EW'(o_c[i]) - EW'(k0[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[0][i] = e1_r[2][i];
      wd[0][i] = pv[i];
      sm[1][i] = sv_r[2][i];
      wd[1][i] = pv[i];
      sm[2][i] = EW'(coord_of(ctx[2].dir, i));
      wd[2][i] = qv[i];
      sm[3][i] = e2_r[2][i];
      wd[3][i] = qv[i];
    end
  end

  always_comb begin
    eps_ok = $unsigned(mag7) >= DW'(eps);
    u_ok   = !nu7[DW-1] && (nu7 <= mag7);
    uv_sum = (DW+1)'(nu7) + (DW+1)'(nv7);
    v_ok   = !nv7[DW-1] && (uv_sum <= (DW+1)'(mag7));
    t_pos  = !nt7[DW-1];
  end

  always_comb begin
    dl  = NW'(lp[0]) + (NW'(lp[1]) << CH) + (NW'(lp[2]) << (2 * CH));
    lhs = LW'(nt8) << FRAC_BITS;
    rhs = LW'(dl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0] <= '{dir: ray_direction, org: ray_start, len: ray_length,
                  ok: m_ok, both: m_both};
      for (int s = 1; s < 8; s++) ctx[s] <= ctx[s-1];

      for (int i = 0; i < 3; i++) begin
        e1_r[0][i] <= e1_n[i];
        e2_r[0][i] <= e2_n[i];
        sv_r[0][i] <= sv_n[i];
        for (int s = 1; s < 3; s++) begin
          e1_r[s][i] <= e1_r[s-1][i];
          e2_r[s][i] <= e2_r[s-1][i];
          sv_r[s][i] <= sv_r[s-1][i];
        end
      end

      // Cross products: pv = dir x e2, qv = s x e1.
      pa[0] <= coord_of(ctx[0].dir, 1) * e2_r[0][2];
      pb[0] <= coord_of(ctx[0].dir, 2) * e2_r[0][1];
      pa[1] <= coord_of(ctx[0].dir, 2) * e2_r[0][0];
      pb[1] <= coord_of(ctx[0].dir, 0) * e2_r[0][2];
      pa[2] <= coord_of(ctx[0].dir, 0) * e2_r[0][1];
      pb[2] <= coord_of(ctx[0].dir, 1) * e2_r[0][0];
      qa[0] <= sv_r[0][1] * e1_r[0][2];
      qb[0] <= sv_r[0][2] * e1_r[0][1];
      qa[1] <= sv_r[0][2] * e1_r[0][0];
      qb[1] <= sv_r[0][0] * e1_r[0][2];
      qa[2] <= sv_r[0][0] * e1_r[0][1];
      qb[2] <= sv_r[0][1] * e1_r[0][0];

      for (int i = 0; i < 3; i++) begin
        pv[i] <= QW'(pa[i]) - QW'(pb[i]);
        qv[i] <= QW'(qa[i]) - QW'(qb[i]);
      end

      // Dot products in two halves of the wide operand, then recombined.
      for (int d = 0; d < 4; d++) begin
        for (int i = 0; i < 3; i++) begin
          lo_pp[d][i] <= sm[d][i] * $signed({1'b0, wd[d][i][LB-1:0]});
          hi_pp[d][i] <= sm[d][i] * $signed(wd[d][i][QW-1:LB]);
        end
        lo_s[d] <= PSW'(lo_pp[d][0]) + PSW'(lo_pp[d][1]) + PSW'(lo_pp[d][2]);
        hi_s[d] <= PSW'(hi_pp[d][0]) + PSW'(hi_pp[d][1]) + PSW'(hi_pp[d][2]);
        dot[d]  <= $signed({hi_s[d], {LB{1'b0}}}) + DW'(lo_s[d]);
      end

      // A negative determinant in both-face mode is folded onto the positive case.
      mag7 <= dot[0][DW-1] ? -dot[0] : dot[0];
      nu7  <= dot[0][DW-1] ? -dot[1] : dot[1];
      nv7  <= dot[0][DW-1] ? -dot[2] : dot[2];
      nt7  <= dot[0][DW-1] ? -dot[3] : dot[3];
      rej7 <= (dot[0] == '0) || (dot[0][DW-1] && !ctx[5].both) || !ctx[5].ok;

      for (int j = 0; j < 3; j++) begin
        lp[j] <= CPW'(mag7[CH*j +: CH]) * CPW'(ctx[6].len);
      end
      nt8   <= nt7;
      den8  <= mag7;
      good8 <= !rej7 && eps_ok && u_ok && v_ok && t_pos;

      out_work.hit <= good8 && (lhs <= rhs);
      out_work.nt  <= nt8;
      out_work.den <= den8;
      out_work.org <= ctx[7].org;
      out_work.dir <= ctx[7].dir;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v[8] && !out_ready) |-> !in_ready)
    else $error("front end takes a transaction while its last stage is stalled");

endmodule

// ===== sv/rti_queue.sv =====
module rti_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rti_pkg::work_t in_work,
  output logic           out_valid,
  input  logic           out_ready,
  output rti_pkg::work_t out_work
);
  import rti_pkg::*;

  work_t          mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;
  logic           push, pop;

  assign in_ready  = cnt != (QAW+1)'(QDEPTH);
  assign out_valid = cnt != '0;
  assign out_work  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QAW+1)'(QDEPTH))
    else $error("queue count exceeds its depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count missed a push");

endmodule

// ===== sv/rti_back.sv =====
module rti_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rti_pkg::work_t          in_work,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [rti_pkg::VW-1:0]  hit_point
);
  import rti_pkg::*;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QBITS-1:0] nb;
    logic [QBITS-1:0] q;
  } divc_t;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] den;
    logic [VW-1:0] org;
    logic [2:0]    dneg;
    divc_t [2:0]   c;
  } divs_t;

  logic adv;

  logic signed [COORD_WIDTH-1:0] dc [3];
  logic [COORD_WIDTH-1:0]        dab [3];

  logic           bv0, hit0;
  logic [DW-1:0]  den0;
  logic [VW-1:0]  org0;
  logic [2:0]     dneg0;
  logic [CPW-1:0] mp [3][3];
  logic [NW-1:0]  n [3];
  divs_t          d0;

  divs_t          dv [QBITS+1];
  divs_t          dn [QBITS];
  logic [QBITS:0] dvv;

  logic [RW:0]    rs [QBITS][3];
  logic           ge [QBITS][3];
  logic           up [3];

  logic             rv, rhit;
  logic [VW-1:0]    rorg;
  logic [2:0]       rdneg;
  logic [QBITS:0]   rq [3];

  logic signed [QBITS+1:0]      sq [3];
  logic signed [SUMW-1:0]       off [3], sum [3];
  logic [COORD_WIDTH-1:0]       pc [3];
  logic [VW-1:0]                pt;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dc[c]  = coord_of(in_work.dir, c);
      dab[c] = dc[c][COORD_WIDTH-1] ? COORD_WIDTH'(-dc[c]) : COORD_WIDTH'(dc[c]);
    end
  end

  // Start of the long division: the top part of the numerator is already below
  // the divisor for any hit, so only QBITS quotient bits remain.
  always_comb begin
    d0.hit  = hit0;
    d0.den  = den0;
    d0.org  = org0;
    d0.dneg = dneg0;
    for (int c = 0; c < 3; c++) begin
      n[c] = NW'(mp[c][0]) + (NW'(mp[c][1]) << CH) + (NW'(mp[c][2]) << (2 * CH));
      d0.c[c].rem = RW'(n[c] >> QBITS);
      d0.c[c].nb  = n[c][QBITS-1:0];
      d0.c[c].q   = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      dn[k] = dv[k];
      for (int c = 0; c < 3; c++) begin
        rs[k][c] = {dv[k].c[c].rem, dv[k].c[c].nb[QBITS-1]};
        ge[k][c] = rs[k][c] >= (RW+1)'(dv[k].den);
        dn[k].c[c].rem = ge[k][c] ? RW'(rs[k][c] - (RW+1)'(dv[k].den)) : RW'(rs[k][c]);
        dn[k].c[c].nb  = dv[k].c[c].nb << 1;
        dn[k].c[c].q   = {dv[k].c[c].q[QBITS-2:0], ge[k][c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // Round to nearest with ties away from zero on the magnitude.
      up[c]  = {dv[QBITS].c[c].rem, 1'b0} >= (RW+1)'(dv[QBITS].den);
      sq[c]  = $signed({1'b0, rq[c]});
      off[c] = rdneg[c] ? -SUMW'(sq[c]) : SUMW'(sq[c]);
      sum[c] = SUMW'(coord_of(rorg, c)) + off[c];
      if (sum[c][SUMW-1:COORD_WIDTH-1] == '0 || sum[c][SUMW-1:COORD_WIDTH-1] == '1) begin
        pc[c] = sum[c][COORD_WIDTH-1:0];
      end else if (sum[c][SUMW-1]) begin
        pc[c] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        pc[c] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      pt[c*COORD_WIDTH +: COORD_WIDTH] = pc[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv0       <= 1'b0;
      dvv       <= '0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      bv0       <= in_valid;
      dvv       <= {dvv[QBITS-1:0], bv0};
      rv        <= dvv[QBITS];
      out_valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit0 <= in_work.hit;
      den0 <= in_work.den;
      org0 <= in_work.org;
      for (int c = 0; c < 3; c++) begin
        dneg0[c] <= dc[c][COORD_WIDTH-1];
        for (int j = 0; j < 3; j++) begin
          mp[c][j] <= CPW'(in_work.nt[CH*j +: CH]) * CPW'(dab[c]);
        end
      end

      dv[0] <= d0;
      for (int k = 0; k < QBITS; k++) dv[k+1] <= dn[k];

      rhit  <= dv[QBITS].hit;
      rorg  <= dv[QBITS].org;
      rdneg <= dv[QBITS].dneg;
      for (int c = 0; c < 3; c++) begin
        rq[c] <= (QBITS+1)'(dv[QBITS].c[c].q) + (QBITS+1)'(up[c]);
      end

      hit       <= rhit;
      hit_point <= rhit ? pt : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> hit_point == '0)
    else $error("hit point is not zero on a miss");

endmodule

// ===== sv/ray_triangle_intersect.sv =====
// Ray segment against triangle test. One test is accepted per clock and one
// result leaves per clock, in order, while out_ready stays high; a low out_ready
// stalls the point unit, and a full queue then stalls the front end. The front
// end (edges, cross and dot products, face and threshold checks, barycentric
// and distance bounds) is a 9-stage pipeline; a 4-entry queue follows it, and
// the point unit behind it has registers for the offset numerators, restoring
// dividers that produce one quotient bit per stage for each coordinate, a
// rounding register and the saturating add into the output register.
// det_epsilon resets to 1074 and is written through the cfg channel, which is
// always ready.
module ray_triangle_intersect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rti_pkg::VW-1:0]           vertex_a,
  input  logic [rti_pkg::VW-1:0]           vertex_b,
  input  logic [rti_pkg::VW-1:0]           vertex_c,
  input  logic [rti_pkg::VW-1:0]           ray_start,
  input  logic [rti_pkg::VW-1:0]           ray_direction,
  input  logic [rti_pkg::COORD_WIDTH-1:0]  ray_length,
  input  logic [1:0]                       face_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic [rti_pkg::VW-1:0]           hit_point
);
  import rti_pkg::*;

  logic [31:0] det_epsilon;
  work_t       f_work, q_work;
  logic        f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= EPS_RESET;
    end else if (cfg_valid) begin
      det_epsilon <= cfg_data;
    end
  end

  rti_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .ray_start     (ray_start),
    .ray_direction (ray_direction),
    .ray_length    (ray_length),
    .face_mode     (face_mode),
    .eps           (det_epsilon),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_work      (f_work)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_work   (f_work),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_work  (q_work)
  );

  rti_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_work   (q_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_point (hit_point)
  );

endmodule
